// File: sv/bpr_pkg.sv
`default_nettype none

package bpr_pkg;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_IMAGE_WIDTH    = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_BITS_PER_PIXEL = 3'd2;
  localparam logic [2:0] REG_START_X        = 3'd3;
  localparam logic [2:0] REG_START_Y        = 3'd4;

  localparam int unsigned SCREEN_WIDTH_DEFAULT = 1024;

  localparam logic [11:0] DIM_MAX          = 12'd2048;
  localparam logic [11:0] RST_IMAGE_WIDTH  = 12'd1;
  localparam logic [11:0] RST_IMAGE_HEIGHT = 12'd1;
  localparam logic [7:0]  RST_BITS_PER_PIX = 8'd24;

  localparam logic [7:0] BPP_16 = 8'd16;
  localparam logic [7:0] BPP_24 = 8'd24;
  localparam logic [7:0] BPP_32 = 8'd32;

  localparam logic [15:0] MASK_BLUE  = 16'h001f;
  localparam logic [15:0] MASK_GREEN = 16'h07e0;
  localparam logic [15:0] MASK_RED   = 16'hf800;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Configuration as the datapath sees it, sizes already clamped.
  typedef struct packed {
    logic [11:0] eff_width;
    logic [11:0] eff_height;
    logic [7:0]  bits_per_pixel;
    logic [10:0] start_x;
    logic [10:0] start_y;
  } cfg_t;

  // One assembled pixel waiting for its address to be worked out.
  typedef struct packed {
    logic [10:0] row;
    logic [10:0] col;
    logic [15:0] color;
    logic        done;
  } pixel_t;

  function automatic logic [11:0] effective_dim(input logic [11:0] v);
    logic [11:0] r;
    r = v;
    if (v == 12'd0) r = 12'd1;
    else if (v > DIM_MAX) r = DIM_MAX;
    return r;
  endfunction

  function automatic logic [15:0] pack565(input logic [7:0] b, input logic [7:0] g,
                                          input logic [7:0] r);
    logic [15:0] bw, gw, rw;
    bw = {8'd0, b} >> 3;
    gw = {8'd0, g} << 3;
    rw = {8'd0, r} << 8;
    return (bw & MASK_BLUE) | (gw & MASK_GREEN) | (rw & MASK_RED);
  endfunction

endpackage

`default_nettype wire

// File: sv/bpr_front.sv
`default_nettype none

module bpr_front import bpr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  input  wire logic       in_valid,
  input  wire logic [7:0] data_byte,
  output logic            out_valid,
  output pixel_t          out_item
);

  logic [1:0]  byte_phase;
  logic [7:0]  saved_byte_a;
  logic [7:0]  saved_byte_b;
  logic [7:0]  saved_byte_c;
  logic [10:0] column_count;
  logic [10:0] row_count;
  logic [1:0]  padding_left;

  logic [2:0]  bytes;
  logic        supported;
  logic        last_byte;
  logic        col_last;
  logic        row_last;
  logic [1:0]  pad;
  logic [15:0] color;

  always_comb begin
    supported = 1'b1;
    case (cfg.bits_per_pixel)
      BPP_16:  bytes = 3'd2;
      BPP_24:  bytes = 3'd3;
      BPP_32:  bytes = 3'd4;
      default: begin
        bytes     = 3'd4;
        supported = 1'b0;
      end
    endcase
    last_byte = {1'b0, byte_phase} >= (bytes - 3'd1);
    col_last  = ({1'b0, column_count} + 12'd1) >= cfg.eff_width;
    row_last  = ({1'b0, row_count} + 12'd1) >= cfg.eff_height;
    // Row length in bytes modulo four only needs the low bits of each factor.
    pad       = 2'(cfg.eff_width[1:0] * bytes[1:0]);
    case (bytes)
      3'd2:    color = {data_byte, saved_byte_a};
      3'd3:    color = pack565(saved_byte_a, saved_byte_b, data_byte);
      default: color = pack565(saved_byte_a, saved_byte_b, saved_byte_c);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase   <= 2'd0;
      saved_byte_a <= 8'd0;
      saved_byte_b <= 8'd0;
      saved_byte_c <= 8'd0;
      column_count <= 11'd0;
      row_count    <= 11'd0;
      padding_left <= 2'd0;
    end else if (in_valid) begin
      if (padding_left != 2'd0) begin
        padding_left <= padding_left - 2'd1;
      end else if (supported) begin
        if (!last_byte) begin
          case (byte_phase)
            2'd0:    saved_byte_a <= data_byte;
            2'd1:    saved_byte_b <= data_byte;
            default: saved_byte_c <= data_byte;
          endcase
          byte_phase <= byte_phase + 2'd1;
        end else begin
          byte_phase <= 2'd0;
          if (col_last) begin
            column_count <= 11'd0;
            if (row_last) begin
              row_count    <= 11'd0;
              padding_left <= 2'd0;
            end else begin
              row_count    <= row_count + 11'd1;
              padding_left <= 2'd0 - pad;
            end
          end else begin
            column_count <= column_count + 11'd1;
          end
        end
      end
    end
  end

  assign out_valid      = in_valid && (padding_left == 2'd0) && supported && last_byte;
  assign out_item.row   = row_count;
  assign out_item.col   = column_count;
  assign out_item.color = color;
  assign out_item.done  = col_last && row_last;

endmodule

`default_nettype wire

// File: sv/bpr_queue.sv
`default_nettype none

module bpr_queue import bpr_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire pixel_t push_item,
  output logic        full,
  input  wire logic   pop,
  output logic        empty,
  output pixel_t      head
);

  localparam logic [QUEUE_AW:0] DEPTH_CNT = (QUEUE_AW + 1)'(QUEUE_DEPTH);
  localparam logic [QUEUE_AW-1:0] LAST_PTR = QUEUE_AW'(QUEUE_DEPTH - 1);

  pixel_t              slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                wr;
  logic                rd;

  assign full  = (count == DEPTH_CNT);
  assign empty = (count == '0);
  assign wr    = push && !full;
  assign rd    = pop && !empty;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) slots[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      if (rd) rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      if (wr && !rd)      count <= count + 1'b1;
      else if (rd && !wr) count <= count - 1'b1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= DEPTH_CNT)
    else $error("queue count beyond depth");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (wr && !rd) |=> count == $past(count) + 1'b1)
    else $error("queue count did not rise on write");
  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (rd && !wr) |=> count == $past(count) - 1'b1)
    else $error("queue count did not fall on read");

endmodule

`default_nettype wire

// File: sv/bpr_back.sv
`default_nettype none

module bpr_back import bpr_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH = SCREEN_WIDTH_DEFAULT
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire cfg_t   cfg,
  input  wire logic   in_valid,
  input  wire pixel_t in_item,
  output logic        in_ready,
  output logic        out_valid,
  input  wire logic   out_ready,
  output logic [21:0] out_index,
  output logic [15:0] out_color,
  output logic        out_done
);

  localparam logic [21:0] SW = 22'(SCREEN_WIDTH);

  logic        s1_valid;
  logic [21:0] s1_prod;
  logic [10:0] s1_col;
  logic [15:0] s1_color;
  logic        s1_done;

  logic [21:0] line;
  logic        s2_free;
  logic        s1_move;
  logic        s1_load;

  assign line     = 22'(cfg.eff_height) - 22'd1 - 22'(in_item.row) + 22'(cfg.start_y);
  assign s2_free  = !out_valid || out_ready;
  assign s1_move  = s1_valid && s2_free;
  assign in_ready = !s1_valid || s2_free;
  assign s1_load  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_prod  <= 22'(line * SW);
      s1_col   <= in_item.col;
      s1_color <= in_item.color;
      s1_done  <= in_item.done;
    end
    if (s1_move) begin
      out_index <= s1_prod + 22'(cfg.start_x) + 22'(s1_col);
      out_color <= s1_color;
      out_done  <= s1_done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_load)      s1_valid <= 1'b1;
      else if (s1_move) s1_valid <= 1'b0;
      if (s1_move)        out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: sv/bmp_pixel_to_rgb565_writer_top.sv
// BMP pixel array to RGB565 framebuffer writer.
//
// Input side: one byte of the pixel array per item, padding bytes included,
// presented on data_byte with push; an item is taken at a clock edge where
// push is high and full is low. Bytes can be taken on every cycle while full stays low.
// Result side: each completed pixel is an item carrying pixel_index,
// pixel_color and frame_done; it is valid while empty is low and leaves on
// a clock edge where pop is high. Padding bytes, the leading bytes of a
// pixel and bytes of an unsupported depth give no item.
// Path: the item of the byte that completes a pixel is written into the queue,
// then passes the two back-end stages (index multiply, then the column add)
// before it shows on the result ports.
// Throughput: one byte per cycle while full stays low and pop keeps up, so up to
// one pixel for every two bytes at 16-bit depth.
// If pop stays low, the result register holds, the back end fills, the
// four-entry queue between the byte front end and the back end fills, and
// full then rises until results are taken again.
// Synchronous reset empties everything and returns the registers to width 1,
// height 1, 24 bits per pixel and start position 0,0.
// Configuration writes are meant for quiet periods and take effect at once.

`default_nettype none

module bmp_pixel_to_rgb565_writer_top import bpr_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH = SCREEN_WIDTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [11:0] cfg_data,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte,
  output logic             empty,
  input  wire logic        pop,
  output logic [21:0]      pixel_index,
  output logic [15:0]      pixel_color,
  output logic             frame_done
);

  logic [11:0] image_width;
  logic [11:0] image_height;
  logic [7:0]  bits_per_pixel;
  logic [10:0] start_x;
  logic [10:0] start_y;

  cfg_t   cfg;
  logic   front_valid;
  pixel_t front_item;
  logic   q_empty;
  pixel_t q_head;
  logic   back_ready;
  logic   res_valid;

  // Register file; writes to indexes outside the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= RST_IMAGE_WIDTH;
      image_height   <= RST_IMAGE_HEIGHT;
      bits_per_pixel <= RST_BITS_PER_PIX;
      start_x        <= 11'd0;
      start_y        <= 11'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:    image_width    <= cfg_data;
        REG_IMAGE_HEIGHT:   image_height   <= cfg_data;
        REG_BITS_PER_PIXEL: bits_per_pixel <= cfg_data[7:0];
        REG_START_X:        start_x        <= cfg_data[10:0];
        REG_START_Y:        start_y        <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // Sizes of zero act as one, and anything above 2048 acts as 2048.
  assign cfg.eff_width      = effective_dim(image_width);
  assign cfg.eff_height     = effective_dim(image_height);
  assign cfg.bits_per_pixel = bits_per_pixel;
  assign cfg.start_x        = start_x;
  assign cfg.start_y        = start_y;

  // The front end sees a byte only when the queue can take what it may make.
  bpr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (push && !full),
    .data_byte (data_byte),
    .out_valid (front_valid),
    .out_item  (front_item)
  );

  bpr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (front_valid),
    .push_item (front_item),
    .full      (full),
    .pop       (back_ready),
    .empty     (q_empty),
    .head      (q_head)
  );

  bpr_back #(
    .SCREEN_WIDTH (SCREEN_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (!q_empty),
    .in_item   (q_head),
    .in_ready  (back_ready),
    .out_valid (res_valid),
    .out_ready (pop),
    .out_index (pixel_index),
    .out_color (pixel_color),
    .out_done  (frame_done)
  );

  assign empty = !res_valid;

endmodule

`default_nettype wire
